@@ rtl/core/white_pixel_mask_centroid_unit_macros.svh @@
// Assertion macros for the white pixel mask and centroid unit.
// Taken in by the port checker; needs clk_i and rst_ni in scope.
`ifndef WHITE_PIXEL_MASK_CENTROID_UNIT_MACROS_SVH
`define WHITE_PIXEL_MASK_CENTROID_UNIT_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define WPMC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define WPMC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/wpmc_pkg.sv @@
// Shared types and constants of the white pixel mask and centroid unit.
// No dependencies.
`timescale 1ns / 1ps
package wpmc_pkg;

  localparam int unsigned ChanW    = 8;
  localparam int unsigned CfgW     = 24;
  localparam int unsigned WidthW   = 13;
  localparam int unsigned OffW     = 15;
  localparam int unsigned QuotW    = 14;
  localparam int unsigned StepW    = 4;
  localparam int unsigned ScaleExt = 15;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = 1;

  localparam logic [QuotW-1:0] FullScale = 14'd12800;

  localparam logic [ChanW-1:0]  ThresholdRst = 8'd180;
  localparam logic [CfgW-1:0]   LimitRst     = 24'd100;
  localparam logic [CfgW-1:0]   MinCountRst  = 24'd30;
  localparam logic [WidthW-1:0] WidthRst     = 13'd640;

  typedef enum logic [1:0] {
    REG_THRESHOLD   = 2'd0,
    REG_WHITE_LIMIT = 2'd1,
    REG_MIN_COUNT   = 2'd2,
    REG_FRAME_WIDTH = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic             last;
    logic             seen;
    logic             calc;
  } pix_t;

endpackage

@@ rtl/core/wpmc_front.sv @@
// Front end: thresholds each pixel, keeps the frame count and column sum,
// and hands classified requests to the queue. Depends on wpmc_pkg.
`timescale 1ns / 1ps
module wpmc_front import wpmc_pkg::*; #(
  parameter int unsigned COLUMN_BITS = 12,
  parameter int unsigned COUNT_BITS  = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                pixel_valid_i,
  output logic                                pixel_ready_o,
  input  logic [ChanW-1:0]                    pixel_red_i,
  input  logic [ChanW-1:0]                    pixel_green_i,
  input  logic [ChanW-1:0]                    pixel_blue_i,
  input  logic [COLUMN_BITS-1:0]              column_i,
  input  logic                                last_in_frame_i,
  input  logic [ChanW-1:0]                    threshold_i,
  input  logic [CfgW-1:0]                     white_limit_i,
  input  logic [CfgW-1:0]                     min_count_i,
  input  logic [WidthW-1:0]                   frame_width_i,
  output logic                                q_valid_o,
  input  logic                                q_ready_i,
  output pix_t                                q_pix_o,
  output logic [COUNT_BITS-1:0]               q_count_o,
  output logic [COUNT_BITS+COLUMN_BITS-1:0]   q_sum_o
);

  localparam int unsigned SumW = COUNT_BITS + COLUMN_BITS;
  localparam int unsigned CntCmpW = (COUNT_BITS > CfgW) ? COUNT_BITS : CfgW;

  logic [COUNT_BITS-1:0] count_q, count_d, count_new;
  logic [SumW-1:0]       sum_q, sum_d, sum_new;
  logic                  accept, white, bump;
  logic [CntCmpW-1:0]    count_ext;

  assign pixel_ready_o = q_ready_i;
  assign q_valid_o     = pixel_valid_i;
  assign accept        = pixel_valid_i && q_ready_i;

  assign white = (pixel_red_i > threshold_i) && (pixel_green_i > threshold_i) &&
                 (pixel_blue_i > threshold_i);
  assign bump      = white && (count_q != '1);
  assign count_new = count_q + COUNT_BITS'(bump);
  assign sum_new   = sum_q + (bump ? SumW'(column_i) : '0);
  assign count_ext = CntCmpW'(count_new);

  always_comb begin
    q_pix_o.red   = white ? pixel_red_i : '0;
    q_pix_o.green = white ? pixel_green_i : '0;
    q_pix_o.blue  = white ? pixel_blue_i : '0;
    q_pix_o.last  = last_in_frame_i;
    q_pix_o.seen  = last_in_frame_i && (count_ext >= CntCmpW'(white_limit_i));
    q_pix_o.calc  = last_in_frame_i && (count_ext >= CntCmpW'(min_count_i)) &&
                    (count_new != '0) && (frame_width_i != '0);
  end

  assign q_count_o = count_new;
  assign q_sum_o   = sum_new;

  always_comb begin
    count_d = count_q;
    sum_d   = sum_q;
    if (accept) begin
      if (last_in_frame_i) begin
        count_d = '0;
        sum_d   = '0;
      end else begin
        count_d = count_new;
        sum_d   = sum_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
    end else begin
      count_q <= count_d;
      sum_q   <= sum_d;
    end
  end

endmodule

@@ rtl/core/wpmc_queue.sv @@
// Short request queue between the front and back ends.
// Depends on wpmc_pkg for its depth.
`timescale 1ns / 1ps
module wpmc_queue import wpmc_pkg::*; #(
  parameter int unsigned DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [DATA_W-1:0] in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DATA_W-1:0] out_data_o
);

  logic [DATA_W-1:0] mem_q [QueueDepth];
  logic [QPtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QPtrW:0]    fill_q, fill_d;
  logic              push, pop;

  assign in_ready_o  = (fill_q != (QPtrW+1)'(QueueDepth));
  assign out_valid_o = (fill_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    fill_d   = fill_q + (QPtrW+1)'(push) - (QPtrW+1)'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

endmodule

@@ rtl/core/wpmc_back.sv @@
// Back end: passes masked pixels to the result register and, at a calc frame end,
// works out the centroid offset with a shift-subtract divider. Depends on wpmc_pkg.
`timescale 1ns / 1ps
module wpmc_back import wpmc_pkg::*; #(
  parameter int unsigned COLUMN_BITS = 12,
  parameter int unsigned COUNT_BITS  = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              q_valid_i,
  output logic                              q_ready_o,
  input  pix_t                              q_pix_i,
  input  logic [COUNT_BITS-1:0]             q_count_i,
  input  logic [COUNT_BITS+COLUMN_BITS-1:0] q_sum_i,
  input  logic [WidthW-1:0]                 frame_width_i,
  output logic                              result_valid_o,
  input  logic                              result_ready_i,
  output logic [ChanW-1:0]                  out_red_o,
  output logic [ChanW-1:0]                  out_green_o,
  output logic [ChanW-1:0]                  out_blue_o,
  output logic                              frame_done_o,
  output logic                              white_seen_o,
  output logic signed [OffW-1:0]            centroid_offset_o
);

  localparam int unsigned SumW = COUNT_BITS + COLUMN_BITS;
  localparam int unsigned TwW  = SumW + 1;
  localparam int unsigned DenW = COUNT_BITS + WidthW;
  localparam int unsigned CmpW = (TwW > DenW) ? TwW : DenW;
  localparam int unsigned NumW = DenW + ScaleExt;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_PREP = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_DONE = 5'b10000
  } back_state_e;

  back_state_e       state_q, state_d;
  logic [DenW-1:0]   den_q, den_d;
  logic [NumW-1:0]   rem_q, rem_d, dsh_q, dsh_d;
  logic [QuotW-1:0]  quot_q, quot_d, mag;
  logic [StepW-1:0]  step_q, step_d;
  logic              neg_q, neg_d, sat_q, sat_d;
  logic              res_valid_q, res_valid_d;
  pix_t              res_pix_q, res_pix_d;
  logic [OffW-1:0]   res_off_q, res_off_d, off_calc;
  logic              out_free, ge;
  logic [CmpW-1:0]   twice, den_ext, diff;
  logic [NumW-1:0]   diff_n;

  assign out_free = !res_valid_q || result_ready_i;

  assign twice   = CmpW'({q_sum_i, 1'b0});
  assign den_ext = CmpW'(den_q);
  assign diff    = (twice < den_ext) ? den_ext - twice : twice - den_ext;
  assign diff_n  = NumW'(diff[DenW-1:0]);
  assign ge      = (rem_q >= dsh_q);
  assign mag     = sat_q ? FullScale : quot_q;
  assign off_calc = neg_q ? OffW'(0) - OffW'(mag) : OffW'(mag);

  always_comb begin
    state_d     = state_q;
    den_d       = den_q;
    rem_d       = rem_q;
    dsh_d       = dsh_q;
    quot_d      = quot_q;
    step_d      = step_q;
    neg_d       = neg_q;
    sat_d       = sat_q;
    res_valid_d = res_valid_q && !result_ready_i;
    res_pix_d   = res_pix_q;
    res_off_d   = res_off_q;
    q_ready_o   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          if (q_pix_i.calc) begin
            state_d = ST_MUL;
          end else if (out_free) begin
            q_ready_o   = 1'b1;
            res_valid_d = 1'b1;
            res_pix_d   = q_pix_i;
            res_off_d   = '0;
          end
        end
      end
      ST_MUL: begin
        den_d   = DenW'(q_count_i) * DenW'(frame_width_i);
        state_d = ST_PREP;
      end
      ST_PREP: begin
        neg_d   = (twice < den_ext);
        sat_d   = (diff >= den_ext);
        rem_d   = (diff_n << 14) + (diff_n << 13) + (diff_n << 10) + NumW'(den_q);
        dsh_d   = NumW'({den_q, 1'b0}) << (QuotW - 1);
        quot_d  = '0;
        step_d  = StepW'(QuotW - 1);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (ge) begin
          rem_d = rem_q - dsh_q;
        end
        quot_d = {quot_q[QuotW-2:0], ge};
        dsh_d  = dsh_q >> 1;
        if (step_q == '0) begin
          state_d = ST_DONE;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          q_ready_o   = 1'b1;
          res_valid_d = 1'b1;
          res_pix_d   = q_pix_i;
          res_off_d   = off_calc;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q     <= den_d;
    rem_q     <= rem_d;
    dsh_q     <= dsh_d;
    quot_q    <= quot_d;
    step_q    <= step_d;
    neg_q     <= neg_d;
    sat_q     <= sat_d;
    res_pix_q <= res_pix_d;
    res_off_q <= res_off_d;
  end

  assign result_valid_o    = res_valid_q;
  assign out_red_o         = res_pix_q.red;
  assign out_green_o       = res_pix_q.green;
  assign out_blue_o        = res_pix_q.blue;
  assign frame_done_o      = res_pix_q.last;
  assign white_seen_o      = res_pix_q.seen;
  assign centroid_offset_o = $signed(res_off_q);

endmodule

@@ rtl/core/white_pixel_mask_centroid_unit.sv @@
// Path: a pixel passes through the queue and then the result register to reach the result port; a frame-end
// pixel that needs an offset also passes the back end's queue hand-off, multiply, set-up, 14-step divider and output.
// Throughput: one pixel per cycle while the queue has room; each frame-end offset holds the back end,
// during which the two-entry queue takes one more pixel and then the input stalls.
// Reset (asynchronous, active low): clears the counters, queue and result valid
// flag, and loads the registers with threshold 180, limits 100 and 30, width 640.
`timescale 1ns / 1ps
module white_pixel_mask_centroid_unit import wpmc_pkg::*; #(
  parameter int unsigned COLUMN_BITS = 12,
  parameter int unsigned COUNT_BITS  = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_idx_i,
  input  logic [CfgW-1:0]        cfg_wdata_i,
  input  logic                   pixel_valid_i,
  output logic                   pixel_ready_o,
  input  logic [ChanW-1:0]       pixel_red_i,
  input  logic [ChanW-1:0]       pixel_green_i,
  input  logic [ChanW-1:0]       pixel_blue_i,
  input  logic [COLUMN_BITS-1:0] column_i,
  input  logic                   last_in_frame_i,
  output logic                   result_valid_o,
  input  logic                   result_ready_i,
  output logic [ChanW-1:0]       out_red_o,
  output logic [ChanW-1:0]       out_green_o,
  output logic [ChanW-1:0]       out_blue_o,
  output logic                   frame_done_o,
  output logic                   white_seen_o,
  output logic signed [OffW-1:0] centroid_offset_o
);

  localparam int unsigned SumW  = COUNT_BITS + COLUMN_BITS;
  localparam int unsigned QDataW = $bits(pix_t) + COUNT_BITS + SumW;

  logic [ChanW-1:0]  threshold_q, threshold_d;
  logic [CfgW-1:0]   limit_q, limit_d, min_count_q, min_count_d;
  logic [WidthW-1:0] width_q, width_d;

  logic              fq_valid, fq_ready, bq_valid, bq_ready;
  pix_t              f_pix, b_pix;
  logic [COUNT_BITS-1:0] f_count, b_count;
  logic [SumW-1:0]   f_sum, b_sum;
  logic [QDataW-1:0] q_in, q_out;

  always_comb begin
    threshold_d = threshold_q;
    limit_d     = limit_q;
    min_count_d = min_count_q;
    width_d     = width_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_THRESHOLD:   threshold_d = cfg_wdata_i[ChanW-1:0];
        REG_WHITE_LIMIT: limit_d     = cfg_wdata_i;
        REG_MIN_COUNT:   min_count_d = cfg_wdata_i;
        REG_FRAME_WIDTH: width_d     = cfg_wdata_i[WidthW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= ThresholdRst;
      limit_q     <= LimitRst;
      min_count_q <= MinCountRst;
      width_q     <= WidthRst;
    end else begin
      threshold_q <= threshold_d;
      limit_q     <= limit_d;
      min_count_q <= min_count_d;
      width_q     <= width_d;
    end
  end

  wpmc_front #(
    .COLUMN_BITS(COLUMN_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pixel_valid_i  (pixel_valid_i),
    .pixel_ready_o  (pixel_ready_o),
    .pixel_red_i    (pixel_red_i),
    .pixel_green_i  (pixel_green_i),
    .pixel_blue_i   (pixel_blue_i),
    .column_i       (column_i),
    .last_in_frame_i(last_in_frame_i),
    .threshold_i    (threshold_q),
    .white_limit_i  (limit_q),
    .min_count_i    (min_count_q),
    .frame_width_i  (width_q),
    .q_valid_o      (fq_valid),
    .q_ready_i      (fq_ready),
    .q_pix_o        (f_pix),
    .q_count_o      (f_count),
    .q_sum_o        (f_sum)
  );

  assign q_in = {f_pix, f_count, f_sum};
  assign {b_pix, b_count, b_sum} = q_out;

  wpmc_queue #(
    .DATA_W(QDataW)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (fq_valid),
    .in_ready_o (fq_ready),
    .in_data_i  (q_in),
    .out_valid_o(bq_valid),
    .out_ready_i(bq_ready),
    .out_data_o (q_out)
  );

  wpmc_back #(
    .COLUMN_BITS(COLUMN_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (bq_valid),
    .q_ready_o        (bq_ready),
    .q_pix_i          (b_pix),
    .q_count_i        (b_count),
    .q_sum_i          (b_sum),
    .frame_width_i    (width_q),
    .result_valid_o   (result_valid_o),
    .result_ready_i   (result_ready_i),
    .out_red_o        (out_red_o),
    .out_green_o      (out_green_o),
    .out_blue_o       (out_blue_o),
    .frame_done_o     (frame_done_o),
    .white_seen_o     (white_seen_o),
    .centroid_offset_o(centroid_offset_o)
  );

endmodule

@@ rtl/core/wpmc_checker.sv @@
// Port-level checks on the result channel of the unit, bound to the top level.
// Depends on white_pixel_mask_centroid_unit_macros.svh and wpmc_pkg.
`timescale 1ns / 1ps
`include "white_pixel_mask_centroid_unit_macros.svh"
module wpmc_checker import wpmc_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   result_valid_o,
  input logic                   result_ready_i,
  input logic [ChanW-1:0]       out_red_o,
  input logic [ChanW-1:0]       out_green_o,
  input logic [ChanW-1:0]       out_blue_o,
  input logic                   frame_done_o,
  input logic                   white_seen_o,
  input logic signed [OffW-1:0] centroid_offset_o
);

  `WPMC_ASSERT_NEXT(a_result_hold, result_valid_o && !result_ready_i, result_valid_o && $stable(out_red_o) && $stable(frame_done_o) && $stable(centroid_offset_o), "stalled result changed")
  `WPMC_ASSERT_NOW(a_summary_only_at_end, result_valid_o && !frame_done_o, !white_seen_o && (centroid_offset_o == '0), "frame summary outside frame end")
  `WPMC_ASSERT_NOW(a_offset_range, result_valid_o, (centroid_offset_o >= -15'sd12800) && (centroid_offset_o <= 15'sd12800), "offset out of range")
  `WPMC_ASSERT_NOW(a_mask_whole, result_valid_o, ((out_red_o == '0) && (out_green_o == '0) && (out_blue_o == '0)) || ((out_red_o != '0) && (out_green_o != '0) && (out_blue_o != '0)), "partially masked pixel")

endmodule

bind white_pixel_mask_centroid_unit wpmc_checker u_wpmc_checker (.*);

@@ tb/white_pixel_mask_centroid_unit_tb.sv @@
// Testbench for white_pixel_mask_centroid_unit: directed and random pixel frames,
// checked against an in-bench model of the mask, count, column sum and centroid.
// Depends on wpmc_pkg and the unit itself.
`timescale 1ns / 1ps
module white_pixel_mask_centroid_unit_tb;
  import wpmc_pkg::*;

  localparam int unsigned ColW   = 12;
  localparam int unsigned CountW = 24;
  localparam int unsigned SumW   = CountW + ColW;
  localparam int unsigned StallLimit = 4000;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic [ColW-1:0]  column;
    logic             last;
  } pixel_req_t;

  typedef struct packed {
    logic [ChanW-1:0]       red;
    logic [ChanW-1:0]       green;
    logic [ChanW-1:0]       blue;
    logic                   done;
    logic                   seen;
    logic signed [OffW-1:0] offset;
  } pixel_result_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [1:0]             cfg_idx_i = '0;
  logic [CfgW-1:0]        cfg_wdata_i = '0;
  logic                   pixel_valid_i = 1'b0;
  logic                   pixel_ready_o;
  logic [ChanW-1:0]       pixel_red_i = '0;
  logic [ChanW-1:0]       pixel_green_i = '0;
  logic [ChanW-1:0]       pixel_blue_i = '0;
  logic [ColW-1:0]        column_i = '0;
  logic                   last_in_frame_i = 1'b0;
  logic                   result_valid_o;
  logic                   result_ready_i = 1'b0;
  logic [ChanW-1:0]       out_red_o;
  logic [ChanW-1:0]       out_green_o;
  logic [ChanW-1:0]       out_blue_o;
  logic                   frame_done_o;
  logic                   white_seen_o;
  logic signed [OffW-1:0] centroid_offset_o;

  white_pixel_mask_centroid_unit #(
    .COLUMN_BITS(ColW),
    .COUNT_BITS (CountW)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .pixel_valid_i    (pixel_valid_i),
    .pixel_ready_o    (pixel_ready_o),
    .pixel_red_i      (pixel_red_i),
    .pixel_green_i    (pixel_green_i),
    .pixel_blue_i     (pixel_blue_i),
    .column_i         (column_i),
    .last_in_frame_i  (last_in_frame_i),
    .result_valid_o   (result_valid_o),
    .result_ready_i   (result_ready_i),
    .out_red_o        (out_red_o),
    .out_green_o      (out_green_o),
    .out_blue_o       (out_blue_o),
    .frame_done_o     (frame_done_o),
    .white_seen_o     (white_seen_o),
    .centroid_offset_o(centroid_offset_o)
  );

  // register copies and frame accumulators of the model
  logic [ChanW-1:0]  cfg_threshold = ThresholdRst;
  logic [CfgW-1:0]   cfg_white_limit = LimitRst;
  logic [CfgW-1:0]   cfg_min_count = MinCountRst;
  logic [WidthW-1:0] cfg_width = WidthRst;
  logic [CountW-1:0] frame_whites = '0;
  logic [SumW-1:0]   frame_column_sum = '0;

  pixel_req_t    pending_pixels[$];
  pixel_result_t due_results[$];
  pixel_req_t    sent_pixel;
  pixel_result_t due;
  int            error_count = 0;
  int            queued_pixels = 0;
  int            stall_cycles = 0;
  int unsigned   cycle_no = 0;
  logic          steady;

  assign steady = (cycle_no[9:8] == 2'd1);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic signed [OffW-1:0] offset_from_centre(logic [CountW-1:0] n,
                                                                 logic [SumW-1:0] sum,
                                                                 logic [WidthW-1:0] w);
    longint unsigned twice;
    longint unsigned den;
    longint unsigned diff;
    longint unsigned mag;
    bit below;
    if (n == 0 || w == 0) return '0;
    twice = 64'(sum) << 1;
    den = 64'(n) * 64'(w);
    below = twice < den;
    diff = below ? den - twice : twice - den;
    if (diff >= den) mag = 64'(FullScale);
    else mag = (64'(FullScale) * diff * 2 + den) / (2 * den);
    return below ? OffW'(64'd0 - mag) : OffW'(mag);
  endfunction

  function automatic pixel_result_t mask_pixel(pixel_req_t p);
    pixel_result_t r;
    bit white;
    r = '0;
    white = p.red > cfg_threshold && p.green > cfg_threshold && p.blue > cfg_threshold;
    if (white) begin
      if (frame_whites != '1) begin
        frame_whites = frame_whites + 1'b1;
        frame_column_sum = frame_column_sum + SumW'(p.column);
      end
      r.red = p.red;
      r.green = p.green;
      r.blue = p.blue;
    end
    r.done = p.last;
    if (p.last) begin
      r.seen = frame_whites >= cfg_white_limit;
      if (frame_whites >= cfg_min_count)
        r.offset = offset_from_centre(frame_whites, frame_column_sum, cfg_width);
      frame_whites = '0;
      frame_column_sum = '0;
    end
    return r;
  endfunction

  task automatic flag_mismatch(string what, longint got, longint want);
    $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    error_count++;
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CfgW-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_THRESHOLD:   cfg_threshold = val[ChanW-1:0];
      REG_WHITE_LIMIT: cfg_white_limit = val;
      REG_MIN_COUNT:   cfg_min_count = val;
      REG_FRAME_WIDTH: cfg_width = val[WidthW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic configure(int unsigned thr, int unsigned limit, int unsigned minc,
                           int unsigned width);
    write_reg(REG_THRESHOLD, CfgW'(thr));
    write_reg(REG_WHITE_LIMIT, CfgW'(limit));
    write_reg(REG_MIN_COUNT, CfgW'(minc));
    write_reg(REG_FRAME_WIDTH, CfgW'(width));
  endtask

  task automatic add_pixel(int unsigned r, int unsigned g, int unsigned b, int unsigned c,
                           bit l);
    pixel_req_t p;
    p.red = ChanW'(r);
    p.green = ChanW'(g);
    p.blue = ChanW'(b);
    p.column = ColW'(c);
    p.last = l;
    pending_pixels.push_back(p);
    queued_pixels++;
  endtask

  // raster frames wrap the column at the frame width (4096 if it is 0 or above 4096); others scatter columns
  task automatic queue_frame(int unsigned len, int unsigned white_pct, bit raster);
    int unsigned span;
    int unsigned start;
    int unsigned c;
    int unsigned ch[3];
    span = (cfg_width == 0 || cfg_width > 4096) ? 4096 : cfg_width;
    start = $urandom_range(span - 1, 0);
    for (int unsigned k = 0; k < len; k++) begin
      c = raster ? (start + k) % span : $urandom_range(4095, 0);
      if ($urandom_range(99, 0) < 10) begin
        foreach (ch[i]) ch[i] = $urandom_range(255, 0);
      end else if ($urandom_range(99, 0) < white_pct && cfg_threshold != 8'hFF) begin
        foreach (ch[i]) ch[i] = $urandom_range(255, cfg_threshold + 1);
      end else begin
        foreach (ch[i]) ch[i] = $urandom_range(255, 0);
        ch[$urandom_range(2, 0)] = $urandom_range(cfg_threshold, 0);
      end
      add_pixel(ch[0], ch[1], ch[2], c, k == len - 1);
    end
  endtask

  task automatic drain();
    while (pending_pixels.size() != 0 || pixel_valid_i || due_results.size() != 0)
      @(posedge clk_i);
    repeat (24) @(posedge clk_i);
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_valid_i <= 1'b0;
    end else begin
      if (pixel_valid_i && pixel_ready_o)
        due_results.push_back(mask_pixel({pixel_red_i, pixel_green_i, pixel_blue_i,
                                          column_i, last_in_frame_i}));
      if (!pixel_valid_i || pixel_ready_o) begin
        if (pending_pixels.size() != 0 && (steady || $urandom_range(99, 0) >= 33)) begin
          sent_pixel = pending_pixels.pop_front();
          pixel_valid_i <= 1'b1;
          pixel_red_i <= sent_pixel.red;
          pixel_green_i <= sent_pixel.green;
          pixel_blue_i <= sent_pixel.blue;
          column_i <= sent_pixel.column;
          last_in_frame_i <= sent_pixel.last;
        end else begin
          pixel_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_ready_i <= 1'b0;
    end else begin
      if (result_valid_o && result_ready_i) begin
        if (due_results.size() == 0) begin
          flag_mismatch("unexpected result", 1, 0);
        end else begin
          due = due_results.pop_front();
          if (out_red_o !== due.red) flag_mismatch("out_red", out_red_o, due.red);
          if (out_green_o !== due.green) flag_mismatch("out_green", out_green_o, due.green);
          if (out_blue_o !== due.blue) flag_mismatch("out_blue", out_blue_o, due.blue);
          if (frame_done_o !== due.done) flag_mismatch("frame_done", frame_done_o, due.done);
          if (white_seen_o !== due.seen) flag_mismatch("white_seen", white_seen_o, due.seen);
          if (centroid_offset_o !== due.offset)
            flag_mismatch("centroid_offset", centroid_offset_o, due.offset);
        end
      end
      result_ready_i <= steady || ($urandom_range(99, 0) >= 33);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_no <= cycle_no + 1;
    if ((pixel_valid_i && pixel_ready_o) || (result_valid_o && result_ready_i) ||
        (pending_pixels.size() == 0 && !pixel_valid_i && due_results.size() == 0)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("** white_pixel_mask_centroid_unit: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int target;
    int unsigned lim;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    configure(180, 2, 1, 640);
    add_pixel(180, 255, 255, 0, 0);
    add_pixel(255, 180, 255, 1, 0);
    add_pixel(255, 255, 180, 2, 0);
    add_pixel(181, 181, 181, 4095, 0);
    add_pixel(255, 255, 255, 0, 1);
    add_pixel(0, 0, 0, 0, 1);
    add_pixel(200, 200, 200, 0, 1);
    add_pixel(255, 255, 255, 320, 1);
    add_pixel(190, 200, 210, 100, 0);
    add_pixel(190, 200, 210, 101, 1);
    add_pixel(8'hAA, 8'h55, 8'hFF, 12'hAAA, 0);
    add_pixel(8'hFF, 8'hFF, 8'hFF, 12'h555, 0);
    add_pixel(8'hFF, 8'hFF, 8'hFF, 12'hAAA, 1);
    add_pixel(255, 255, 255, 479, 0);
    add_pixel(255, 255, 255, 481, 0);
    add_pixel(255, 255, 255, 639, 1);
    add_pixel(255, 255, 255, 700, 1);
    drain();

    configure(180, 100, 30, 640);
    target = queued_pixels + 250;
    while (queued_pixels < target)
      queue_frame($urandom_range(180, 60), $urandom_range(90, 10), 1'b1);
    drain();

    configure(0, 0, 0, 0);
    target = queued_pixels + 60;
    while (queued_pixels < target) queue_frame($urandom_range(10, 1), 50, $urandom_range(1, 0));
    drain();

    configure(255, 24'hFFFFFF, 24'hFFFFFF, 8191);
    target = queued_pixels + 50;
    while (queued_pixels < target) queue_frame($urandom_range(20, 1), 50, 1'b0);
    drain();

    for (int s = 0; s < 3; s++) begin
      lim = $urandom_range(25, 0);
      configure($urandom_range(255, 0), lim, $urandom_range(25, 0),
                s == 0 ? 1 : $urandom_range(4096, 1));
      target = queued_pixels + 110;
      while (queued_pixels < target)
        queue_frame($urandom_range(40, 1), $urandom_range(100, 0), $urandom_range(3, 0) != 0);
      drain();
    end

    if (error_count == 0) begin
      $display("** white_pixel_mask_centroid_unit: PASSED **");
    end else begin
      $display("** white_pixel_mask_centroid_unit: FAILED **");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/wpmc_pkg.sv
rtl/core/wpmc_front.sv
rtl/core/wpmc_queue.sv
rtl/core/wpmc_back.sv
rtl/core/white_pixel_mask_centroid_unit.sv
rtl/core/wpmc_checker.sv
tb/white_pixel_mask_centroid_unit_tb.sv
